// ===== src/box_smoothing_3x3_edge_clipped_macros.svh =====
// Assertion macros shared by the 3x3 box smoothing modules.
`ifndef BOX_SMOOTHING_3X3_EDGE_CLIPPED_MACROS_SVH
`define BOX_SMOOTHING_3X3_EDGE_CLIPPED_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bsm_pkg.sv =====
// Types and constants shared by the 3x3 box smoothing modules.
`default_nettype none

package bsm_pkg;

    localparam int PIX_W = 8;
    localparam int SIZE_W = 5;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd8;

    // Reciprocals for the divisors 6 and 9, scaled by 2**RCP_SHIFT and rounded up.
    // Exact for every sum that a clipped 3x3 window can produce.
    localparam int RCP_SHIFT = 16;
    localparam logic [15:0] RCP_DIV6 = 16'd10923;
    localparam logic [15:0] RCP_DIV9 = 16'd7282;

    // One column of the window: oldest row on top.
    typedef struct packed {
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic [PIX_W-1:0] bot;
    } t_col;

    // What one column step asks of the window stage.
    typedef struct packed {
        logic emit_c;     // emit the result centered on the previous column
        logic emit_e;     // then emit the row-end result centered on this column
        logic left_ok;    // left neighbor column lies inside the frame
        logic top_ok;     // upper neighbor row lies inside the frame
        logic bot_ok;     // lower neighbor row lies inside the frame
        logic last_mark;  // final result of this step closes the input item
        logic done_mark;  // final result of this step closes the frame
    } t_evt;

    // One window handed to the mean unit.
    typedef struct packed {
        t_col left;
        t_col center;
        t_col right;
        logic left_ok;
        logic right_ok;
        logic top_ok;
        logic bot_ok;
        logic last;
        logic done;
    } t_win;

    typedef enum logic {
        FEED_PIXEL,
        FEED_FLUSH
    } t_feed_state;

endpackage

`default_nettype wire

// ===== src/box_smoothing_3x3_edge_clipped.sv =====
// Top level of the 3x3 box smoothing filter with borders clipped to the frame.
//
//  Channel      Direction  Handshake                    Payload
//  s_axis       in         s_axis_tvalid/s_axis_tready  pixel
//  m_axis       out        m_axis_tvalid/m_axis_tready  smoothed, last_of_run, frame_done
//  cfg          in         i_cfg_valid/o_cfg_ready      frame_size
//
// An input item is taken every cycle while the output side keeps up. A pixel
// passes the input register and the window registers on its way to the output
// register. The last pixel of a row after the first causes two results, which
// holds s_axis_tready low while the first leaves. After the last pixel of a frame
// the line RAM is read back once per column, so the input stays closed during
// these reads and the row-end result of that pixel, while the final row of
// results drains. Reset (synchronous, active low) clears the counters and sets
// the frame size to 8; the line RAM needs no clearing pass, since stale entries
// only feed cells outside the frame. A stalled m_axis holds the pipe, losing no item.
`default_nettype none

module box_smoothing_3x3_edge_clipped #(
    parameter int MAX_SIZE = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [4:0]  i_cfg_data,      // [4:0] frame_size

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,    // [7:0] pixel

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,    // [7:0] smoothed
    output logic             m_axis_tlast,    // last_of_run
    output logic             m_axis_tuser     // [0] frame_done
);

    // Column steps from the input side to the window.
    logic          evt_valid;
    bsm_pkg::t_evt evt;
    bsm_pkg::t_col col;
    logic          take;

    // Windows from the window stage to the mean unit.
    logic          win_valid;
    bsm_pkg::t_win win;
    logic          win_ready;

    // Counters, line RAM and the read-back of the last row at frame end.
    bsm_feed #(
        .MAX_SIZE(MAX_SIZE)
    ) u_feed (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_cfg_ready(o_cfg_ready),
        .i_pix_valid(s_axis_tvalid),
        .i_pix      (s_axis_tdata),
        .o_pix_ready(s_axis_tready),
        .o_evt_valid(evt_valid),
        .o_evt      (evt),
        .o_col      (col),
        .i_take     (take)
    );

    // Three columns of the neighborhood and the order of the results per step.
    bsm_win u_win (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt_valid(evt_valid),
        .i_evt      (evt),
        .i_col      (col),
        .o_take     (take),
        .o_win_valid(win_valid),
        .o_win      (win),
        .i_win_ready(win_ready)
    );

    // Sum over the in-frame cells, divide, and register the result item.
    bsm_mean u_mean (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (win_valid),
        .i_win     (win),
        .o_ready   (win_ready),
        .o_valid   (m_axis_tvalid),
        .o_smoothed(m_axis_tdata),
        .o_last    (m_axis_tlast),
        .o_done    (m_axis_tuser),
        .i_ready   (m_axis_tready)
    );

endmodule

`default_nettype wire

// ===== src/bsm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bsm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== src/bsm_feed.sv =====
// Input side: frame counters, line RAM, end-of-frame flush sequencer and input register.
`default_nettype none
`include "box_smoothing_3x3_edge_clipped_macros.svh"

module bsm_feed #(
    parameter int MAX_SIZE = 16,
    localparam int AW = $clog2(MAX_SIZE)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [bsm_pkg::SIZE_W-1:0]    i_cfg_data,
    output logic                               o_cfg_ready,
    input  wire logic                          i_pix_valid,
    input  wire logic [bsm_pkg::PIX_W-1:0]     i_pix,
    output logic                               o_pix_ready,
    output logic                               o_evt_valid,
    output bsm_pkg::t_evt                      o_evt,
    output bsm_pkg::t_col                      o_col,
    input  wire logic                          i_take
);

    localparam int NW = $clog2(MAX_SIZE + 1);
    localparam int CW = (NW > bsm_pkg::SIZE_W) ? NW : bsm_pkg::SIZE_W;
    localparam int RW = 2 * bsm_pkg::PIX_W;

    logic [bsm_pkg::SIZE_W-1:0] r_frame_size;
    logic [AW-1:0]              r_row;
    logic [AW-1:0]              r_col;
    logic [AW-1:0]              r_fcnt;
    bsm_pkg::t_feed_state       r_state;
    bsm_pkg::t_feed_state       n_state;

    logic                       r_s1_valid;
    logic [bsm_pkg::PIX_W-1:0]  r_s1_pix;
    logic [AW-1:0]              r_s1_addr;
    logic                       r_s1_flush;
    bsm_pkg::t_evt              r_s1_evt;
    bsm_pkg::t_evt              n_evt;

    logic [CW-1:0] size_ext;
    logic [NW-1:0] n_eff;
    logic [AW-1:0] last_idx;
    logic          cfg_fire;
    logic          s1_load;
    logic          pix_ready;
    logic          flush_gen;
    logic          pix_fire;
    logic          row_end;
    logic          frame_end;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [RW-1:0] wr_data;
    logic [RW-1:0] rd_data;

    // Effective side length, saturated to 2 .. MAX_SIZE.
    always_comb begin
        size_ext = CW'(r_frame_size);
        if (size_ext < CW'(2)) begin
            n_eff = NW'(2);
        end else if (size_ext > CW'(MAX_SIZE)) begin
            n_eff = NW'(MAX_SIZE);
        end else begin
            n_eff = NW'(size_ext);
        end
    end

    assign last_idx  = AW'(n_eff - NW'(1));
    assign cfg_fire  = i_cfg_valid;
    assign s1_load   = !r_s1_valid || i_take;
    assign pix_fire  = i_pix_valid && pix_ready;
    assign row_end   = (r_col == last_idx);
    assign frame_end = row_end && (r_row == last_idx);

    always_comb begin
        n_state = r_state;
        case (r_state)
            bsm_pkg::FEED_PIXEL: begin
                if (pix_fire && frame_end) begin
                    n_state = bsm_pkg::FEED_FLUSH;
                end
            end
            bsm_pkg::FEED_FLUSH: begin
                if (flush_gen && (r_fcnt == last_idx)) begin
                    n_state = bsm_pkg::FEED_PIXEL;
                end
            end
            default: begin
                n_state = bsm_pkg::FEED_PIXEL;
            end
        endcase
        if (cfg_fire) begin
            n_state = bsm_pkg::FEED_PIXEL;
        end
    end

    always_comb begin
        pix_ready = 1'b0;
        flush_gen = 1'b0;
        case (r_state)
            bsm_pkg::FEED_PIXEL: begin
                pix_ready = s1_load;
            end
            bsm_pkg::FEED_FLUSH: begin
                flush_gen = s1_load;
            end
            default: begin
                pix_ready = 1'b0;
            end
        endcase
    end

    // Which results the step will cause, worked out from the counters.
    always_comb begin
        if (r_state == bsm_pkg::FEED_FLUSH) begin
            n_evt.emit_c    = (r_fcnt != '0);
            n_evt.emit_e    = (r_fcnt == last_idx);
            n_evt.left_ok   = (r_fcnt > AW'(1));
            n_evt.top_ok    = 1'b1;
            n_evt.bot_ok    = 1'b0;
            n_evt.last_mark = (r_fcnt == last_idx);
            n_evt.done_mark = (r_fcnt == last_idx);
            rd_addr         = r_fcnt;
        end else begin
            n_evt.emit_c    = (r_row != '0) && (r_col != '0);
            n_evt.emit_e    = (r_row != '0) && row_end;
            n_evt.left_ok   = (r_col > AW'(1));
            n_evt.top_ok    = (r_row > AW'(1));
            n_evt.bot_ok    = 1'b1;
            n_evt.last_mark = !frame_end;
            n_evt.done_mark = 1'b0;
            rd_addr         = r_col;
        end
    end

    assign rd_en   = pix_fire || flush_gen;
    assign wr_en   = i_take && r_s1_valid && !r_s1_flush;
    assign wr_data = {rd_data[bsm_pkg::PIX_W-1:0], r_s1_pix};

    bsm_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_SIZE)
    ) u_line_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(r_s1_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bsm_pkg::FEED_PIXEL;
            r_frame_size <= bsm_pkg::SIZE_RESET;
            r_row        <= '0;
            r_col        <= '0;
            r_fcnt       <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_fire) begin
                r_frame_size <= i_cfg_data;
                r_row        <= '0;
                r_col        <= '0;
                r_fcnt       <= '0;
            end else begin
                if (pix_fire) begin
                    if (row_end) begin
                        r_col <= '0;
                        r_row <= frame_end ? '0 : r_row + AW'(1);
                    end else begin
                        r_col <= r_col + AW'(1);
                    end
                end
                if (flush_gen) begin
                    r_fcnt <= (r_fcnt == last_idx) ? '0 : r_fcnt + AW'(1);
                end
            end
            if (s1_load) begin
                r_s1_valid <= pix_fire || flush_gen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_s1_pix   <= i_pix;
            r_s1_addr  <= rd_addr;
            r_s1_flush <= flush_gen;
            r_s1_evt   <= n_evt;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_pix_ready = pix_ready;
    assign o_evt_valid = r_s1_valid;
    assign o_evt       = r_s1_evt;
    assign o_col       = '{top: rd_data[RW-1:bsm_pkg::PIX_W],
                           mid: rd_data[bsm_pkg::PIX_W-1:0],
                           bot: r_s1_pix};

    `BSM_ASSERT_NEXT(a_flush_follows_frame, i_clk, i_rst_n, pix_fire && frame_end && !cfg_fire, (r_state == bsm_pkg::FEED_FLUSH) && (r_row == '0) && (r_col == '0), "last pixel of a frame did not start the flush")
    `BSM_ASSERT_NEXT(a_flush_returns, i_clk, i_rst_n, flush_gen && (r_fcnt == last_idx) && !cfg_fire, (r_state == bsm_pkg::FEED_PIXEL) && (r_fcnt == '0), "flush did not end after the last column")

endmodule

`default_nettype wire

// ===== src/bsm_win.sv =====
// Sliding 3x3 window and the sequencing of the one or two results of each column step.
`default_nettype none
`include "box_smoothing_3x3_edge_clipped_macros.svh"

module bsm_win (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_evt_valid,
    input  wire bsm_pkg::t_evt i_evt,
    input  wire bsm_pkg::t_col i_col,
    output logic               o_take,
    output logic               o_win_valid,
    output bsm_pkg::t_win      o_win,
    input  wire logic          i_win_ready
);

    bsm_pkg::t_col r_left;
    bsm_pkg::t_col r_center;
    bsm_pkg::t_col r_right;
    bsm_pkg::t_evt r_evt;
    logic          r_need_c;
    logic          r_need_e;

    logic busy;
    logic take;
    logic emit_fire;

    assign busy      = r_need_c || r_need_e;
    assign emit_fire = busy && i_win_ready;
    // A new step may enter once the last pending result leaves in this cycle.
    assign take      = i_evt_valid && (!busy || (i_win_ready && (r_need_c ^ r_need_e)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_need_c <= 1'b0;
            r_need_e <= 1'b0;
        end else if (take) begin
            r_need_c <= i_evt.emit_c;
            r_need_e <= i_evt.emit_e;
        end else if (emit_fire) begin
            if (r_need_c) begin
                r_need_c <= 1'b0;
            end else begin
                r_need_e <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_left   <= r_center;
            r_center <= r_right;
            r_right  <= i_col;
            r_evt    <= i_evt;
        end
    end

    always_comb begin
        if (r_need_c) begin
            o_win.left     = r_left;
            o_win.center   = r_center;
            o_win.right    = r_right;
            o_win.left_ok  = r_evt.left_ok;
            o_win.right_ok = 1'b1;
            o_win.last     = r_evt.last_mark && !r_evt.emit_e;
            o_win.done     = r_evt.done_mark && !r_evt.emit_e;
        end else begin
            // Row end: the newest column is the center and has no right neighbor.
            o_win.left     = r_center;
            o_win.center   = r_right;
            o_win.right    = r_right;
            o_win.left_ok  = 1'b1;
            o_win.right_ok = 1'b0;
            o_win.last     = r_evt.last_mark;
            o_win.done     = r_evt.done_mark;
        end
        o_win.top_ok = r_evt.top_ok;
        o_win.bot_ok = r_evt.bot_ok;
    end

    assign o_take      = take;
    assign o_win_valid = busy;

    `BSM_ASSERT_NEXT(a_row_end_pending, i_clk, i_rst_n, take && i_evt.emit_e, r_need_e, "row-end result was not queued")

endmodule

`default_nettype wire

// ===== src/bsm_mean.sv =====
// Clipped 3x3 sum, division by 4, 6 or 9, and the output register.
`default_nettype none
`include "box_smoothing_3x3_edge_clipped_macros.svh"

module bsm_mean (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    input  wire bsm_pkg::t_win             i_win,
    output logic                           o_ready,
    output logic                           o_valid,
    output logic [bsm_pkg::PIX_W-1:0]      o_smoothed,
    output logic                           o_last,
    output logic                           o_done,
    input  wire logic                      i_ready
);

    logic [9:0]  sum_l;
    logic [9:0]  sum_c;
    logic [9:0]  sum_r;
    logic [11:0] sum;
    logic [27:0] prod;
    logic [bsm_pkg::PIX_W-1:0] mean;
    logic three_rows;
    logic three_cols;
    logic load;

    logic                      r_valid;
    logic [bsm_pkg::PIX_W-1:0] r_smoothed;
    logic                      r_last;
    logic                      r_done;

    assign three_rows = i_win.top_ok && i_win.bot_ok;
    assign three_cols = i_win.left_ok && i_win.right_ok;

    always_comb begin
        sum_l = 10'(i_win.left.mid)
              + (i_win.top_ok ? 10'(i_win.left.top) : 10'd0)
              + (i_win.bot_ok ? 10'(i_win.left.bot) : 10'd0);
        sum_c = 10'(i_win.center.mid)
              + (i_win.top_ok ? 10'(i_win.center.top) : 10'd0)
              + (i_win.bot_ok ? 10'(i_win.center.bot) : 10'd0);
        sum_r = 10'(i_win.right.mid)
              + (i_win.top_ok ? 10'(i_win.right.top) : 10'd0)
              + (i_win.bot_ok ? 10'(i_win.right.bot) : 10'd0);
        sum = 12'(sum_c)
            + (i_win.left_ok ? 12'(sum_l) : 12'd0)
            + (i_win.right_ok ? 12'(sum_r) : 12'd0);

        // Interior takes 9 cells, an edge 6, a corner 4.
        if (three_rows && three_cols) begin
            prod = 28'(sum) * 28'(bsm_pkg::RCP_DIV9);
            mean = prod[bsm_pkg::RCP_SHIFT +: bsm_pkg::PIX_W];
        end else if (three_rows || three_cols) begin
            prod = 28'(sum) * 28'(bsm_pkg::RCP_DIV6);
            mean = prod[bsm_pkg::RCP_SHIFT +: bsm_pkg::PIX_W];
        end else begin
            prod = '0;
            mean = sum[9:2];
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_smoothed <= mean;
            r_last     <= i_win.last;
            r_done     <= i_win.done;
        end
    end

    assign o_valid    = r_valid;
    assign o_smoothed = r_smoothed;
    assign o_last     = r_last;
    assign o_done     = r_done;

    `BSM_ASSERT_SAME(a_done_is_last, i_clk, i_rst_n, r_valid && r_done, r_last, "frame end result lacks the end-of-item mark")

endmodule

`default_nettype wire
